[src/bfth_pkg.sv]
// Shared types, constants and codes for the three-hash Bloom filter.
// No dependencies; bfth_alu and bloom_filter_three_hash import this package.
package bfth_pkg;

   // Field widths
   localparam int FILTER_BITS_W = 17;
   localparam int ACTION_W      = 2;
   localparam int BYTE_W        = 8;
   localparam int HASH_W        = 64;

   // Filter size limits and defaults
   localparam int MAX_BITS_DEF     = 65536;
   localparam int MIN_BITS         = 64;
   localparam int FILTER_BITS_RST  = 65536;

   // Hash seeds and multipliers
   localparam logic [HASH_W-1:0] FNV_SEED_A = 64'hCBF2_9CE4_8422_2325;
   localparam logic [HASH_W-1:0] FNV_SEED_B = 64'h5851_F42D_4C95_7F2D;
   localparam logic [HASH_W-1:0] DJB_SEED   = 64'd5381;
   // FNV prime is 2^40 + 0x1B3
   localparam logic [8:0]        FNV_MUL_LO = 9'h1B3;
   localparam int                FNV_MUL_SH = 40;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Shared unit operation codes
   localparam logic [1:0] ALU_FNV = 2'd0;
   localparam logic [1:0] ALU_DJB = 2'd1;
   localparam logic [1:0] ALU_MOD = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   key_byte;
      logic                byte_valid;
      logic                last_byte;
   } req_type;

   typedef struct packed {
      logic [ACTION_W-1:0] done_action;
      logic                maybe_present;
   } rsp_type;

endpackage

[src/bfth_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bfth_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bfth_alu.sv]
// Shared arithmetic unit: FNV-1a step, DJB2a step, or one restoring
// remainder step. Depends on bfth_pkg.
module bfth_alu #(
   parameter int MAX_BITS = bfth_pkg::MAX_BITS_DEF
) (
   input  logic [1:0]                      op,
   input  logic [bfth_pkg::HASH_W-1:0]     opa,
   input  logic [bfth_pkg::BYTE_W-1:0]     key_byte,
   input  logic [$clog2(MAX_BITS+1):0]     rem_cur,
   input  logic [$clog2(MAX_BITS+1)-1:0]   modulus,
   output logic [bfth_pkg::HASH_W-1:0]     res,
   output logic [$clog2(MAX_BITS+1):0]     rem_nxt
);
   import bfth_pkg::*;

   localparam int NW = $clog2(MAX_BITS + 1);
   localparam int RW = NW + 1;

   logic [HASH_W-1:0] mixed;
   logic [HASH_W-1:0] fnv_lo;
   logic [RW-1:0]     shifted;

   always_comb begin
      mixed   = opa ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte};
      fnv_lo  = HASH_W'(mixed * FNV_MUL_LO);
      shifted = {rem_cur[RW-2:0], opa[HASH_W-1]};
      res     = opa;
      rem_nxt = rem_cur;
      case (op)
         ALU_FNV: begin
            // (h ^ b) * (2^40 + 0x1B3), mod 2^64
            res = fnv_lo + {mixed[HASH_W-FNV_MUL_SH-1:0], {FNV_MUL_SH{1'b0}}};
         end
         ALU_DJB: begin
            res = ((opa << 5) + opa) ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte};
         end
         ALU_MOD: begin
            // bring in the next dividend bit, subtract if it fits
            res = opa << 1;
            if (shifted >= {1'b0, modulus}) begin
               rem_nxt = shifted - {1'b0, modulus};
            end else begin
               rem_nxt = shifted;
            end
         end
         default: begin
            res = opa;
         end
      endcase
   end

endmodule

[src/bloom_filter_three_hash.sv]
// Bloom filter over byte-string keys, three hashes through one shared unit.
// Key byte: a transfer, then three hash updates, one hash update per cycle.
// Key end: 64 remainder steps per hash, the bit store phase (add writes three
// bits, query reads three) and the output state. Clear: all store bits, then
// output. Reset runs the same clearing pass; req_stall is high meanwhile.
// Depends on bfth_pkg, bfth_alu, bfth_ram.
module bloom_filter_three_hash #(
   parameter int MAX_BITS = bfth_pkg::MAX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bfth_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bfth_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bfth_pkg::FILTER_BITS_W-1:0]   csr_data
);
   import bfth_pkg::*;

   localparam int NW = $clog2(MAX_BITS + 1);
   localparam int RW = NW + 1;
   localparam int AW = $clog2(MAX_BITS);
   localparam int CW = (NW > FILTER_BITS_W) ? NW : FILTER_BITS_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_MEM   = 3'd3;
   localparam logic [2:0] S_CLEAR = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [HASH_W-1:0]        hash_a_ff, hash_a_in;
   logic [HASH_W-1:0]        hash_b_ff, hash_b_in;
   logic [HASH_W-1:0]        hash_c_ff, hash_c_in;
   logic [HASH_W-1:0]        w_ff, w_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [AW-1:0]            pos_ff [3];
   logic [AW-1:0]            pos_in [3];
   logic [1:0]               hstep_ff, hstep_in;
   logic [5:0]               bit_cnt_ff, bit_cnt_in;
   logic [1:0]               sel_ff, sel_in;
   logic [1:0]               mcnt_ff, mcnt_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic                     clr_emit_ff, clr_emit_in;
   logic [ACTION_W-1:0]      act_ff, act_in;
   logic [BYTE_W-1:0]        key_ff, key_in;
   logic                     last_ff, last_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [FILTER_BITS_W-1:0] filter_bits_ff;

   logic [CW-1:0]            fb_ext;
   logic [CW-1:0]            n_ext;
   logic [NW-1:0]            n_live;
   logic [1:0]               alu_op;
   logic [HASH_W-1:0]        alu_a;
   logic [HASH_W-1:0]        alu_res;
   logic [RW-1:0]            alu_rem;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [AW-1:0]            ram_raddr;
   logic [0:0]               ram_rdata;
   logic [AW-1:0]            cur_pos;

   // Effective bit count, clamped to [MIN_BITS, MAX_BITS]
   always_comb begin
      fb_ext = CW'(filter_bits_ff);
      if (fb_ext < CW'(MIN_BITS)) begin
         n_ext = CW'(MIN_BITS);
      end else if (fb_ext > CW'(MAX_BITS)) begin
         n_ext = CW'(MAX_BITS);
      end else begin
         n_ext = fb_ext;
      end
      n_live = n_ext[NW-1:0];
   end

   // Bit position picked by the store counter
   always_comb begin
      case (mcnt_ff)
         2'd0:    cur_pos = pos_ff[0];
         2'd1:    cur_pos = pos_ff[1];
         default: cur_pos = pos_ff[2];
      endcase
   end

   bfth_alu #(
      .MAX_BITS (MAX_BITS)
   ) u_alu (
      .op       (alu_op),
      .opa      (alu_a),
      .key_byte (key_ff),
      .rem_cur  (rem_ff),
      .modulus  (n_live),
      .res      (alu_res),
      .rem_nxt  (alu_rem)
   );

   // Bit store port control
   assign ram_we    = (state_ff == S_CLEAR) ||
                      (state_ff == S_MEM && act_ff == ACT_ADD && mcnt_ff != 2'd3);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : cur_pos;
   assign ram_raddr = cur_pos;

   bfth_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (1'b0 | (state_ff == S_MEM)),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      hash_a_in    = hash_a_ff;
      hash_b_in    = hash_b_ff;
      hash_c_in    = hash_c_ff;
      w_in         = w_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      hstep_in     = hstep_ff;
      bit_cnt_in   = bit_cnt_ff;
      sel_in       = sel_ff;
      mcnt_in      = mcnt_ff;
      clr_addr_in  = clr_addr_ff;
      clr_emit_in  = clr_emit_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      alu_op       = ALU_MOD;
      alu_a        = w_ff;

      // output register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.action)
                  ACT_ADD, ACT_QUERY: begin
                     act_in  = req_data.action;
                     key_in  = req_data.key_byte;
                     last_in = req_data.last_byte;
                     if (req_data.byte_valid) begin
                        state_in = S_HASH;
                        hstep_in = 2'd0;
                     end else if (req_data.last_byte) begin
                        state_in   = S_MOD;
                        w_in       = hash_a_ff;
                        rem_in     = '0;
                        bit_cnt_in = '0;
                        sel_in     = 2'd0;
                     end
                  end
                  ACT_CLEAR: begin
                     if (req_data.last_byte) begin
                        state_in    = S_CLEAR;
                        clr_addr_in = '0;
                        clr_emit_in = 1'b1;
                        act_in      = ACT_CLEAR;
                        hash_a_in   = FNV_SEED_A;
                        hash_b_in   = FNV_SEED_B;
                        hash_c_in   = DJB_SEED;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_HASH: begin
            // one hash per cycle through the shared unit
            case (hstep_ff)
               2'd0: begin
                  alu_op    = ALU_FNV;
                  alu_a     = hash_a_ff;
                  hash_a_in = alu_res;
               end
               2'd1: begin
                  alu_op    = ALU_FNV;
                  alu_a     = hash_b_ff;
                  hash_b_in = alu_res;
               end
               default: begin
                  alu_op    = ALU_DJB;
                  alu_a     = hash_c_ff;
                  hash_c_in = alu_res;
               end
            endcase
            hstep_in = hstep_ff + 2'd1;
            if (hstep_ff == 2'd2) begin
               if (last_ff) begin
                  state_in   = S_MOD;
                  w_in       = hash_a_ff;
                  rem_in     = '0;
                  bit_cnt_in = '0;
                  sel_in     = 2'd0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_MOD: begin
            // restoring remainder, one dividend bit per cycle
            alu_op     = ALU_MOD;
            alu_a      = w_ff;
            w_in       = alu_res;
            rem_in     = alu_rem;
            bit_cnt_in = bit_cnt_ff + 6'd1;
            if (bit_cnt_ff == 6'd63) begin
               pos_in[sel_ff] = alu_rem[AW-1:0];
               rem_in         = '0;
               if (sel_ff == 2'd2) begin
                  state_in = S_MEM;
                  mcnt_in  = 2'd0;
                  hit_in   = 1'b1;
               end else begin
                  sel_in = sel_ff + 2'd1;
                  w_in   = (sel_ff == 2'd0) ? hash_b_ff : hash_c_ff;
               end
            end
         end

         S_MEM: begin
            // add writes three bits; query reads three, data in the next cycle
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff != 2'd0) begin
               hit_in = hit_ff & ram_rdata[0];
            end
            if ((act_ff == ACT_ADD && mcnt_ff == 2'd2) ||
                (act_ff != ACT_ADD && mcnt_ff == 2'd3)) begin
               state_in  = S_EMIT;
               hash_a_in = FNV_SEED_A;
               hash_b_in = FNV_SEED_B;
               hash_c_in = DJB_SEED;
            end
         end

         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAX_BITS - 1)) begin
               state_in = clr_emit_ff ? S_EMIT : S_IDLE;
               hit_in   = 1'b0;
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.done_action   = act_ff;
               rsp_data_in.maybe_present = (act_ff == ACT_QUERY) & hit_ff;
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and hash state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_emit_ff  <= 1'b0;
         hash_a_ff    <= FNV_SEED_A;
         hash_b_ff    <= FNV_SEED_B;
         hash_c_ff    <= DJB_SEED;
         hstep_ff     <= '0;
         bit_cnt_ff   <= '0;
         sel_ff       <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_emit_ff  <= clr_emit_in;
         hash_a_ff    <= hash_a_in;
         hash_b_ff    <= hash_b_in;
         hash_c_ff    <= hash_c_in;
         hstep_ff     <= hstep_in;
         bit_cnt_ff   <= bit_cnt_in;
         sel_ff       <= sel_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      act_ff      <= act_in;
      key_ff      <= key_in;
      last_ff     <= last_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= FILTER_BITS_W'(FILTER_BITS_RST);
      end else if (csr_valid) begin
         filter_bits_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_hit_only_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.maybe_present |-> rsp_data_ff.done_action == ACT_QUERY)
      else $error("maybe_present set on a non-query result");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside the emit state");

   a_store_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_MEM))
      else $error("bit store written outside clear or store phase");

   a_mem_action: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MEM |-> (act_ff == ACT_ADD || act_ff == ACT_QUERY))
      else $error("store phase entered with a clear action");

endmodule
